// ===== src/psbj_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psbj_pkg;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_FETCH
   } state_type;

   localparam logic [1:0] CSR_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_SWEEPS    = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD = 2'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   localparam logic [2:0] STEP_CENTRE = 3'd0;
   localparam logic [2:0] STEP_LEFT   = 3'd1;
   localparam logic [2:0] STEP_RIGHT  = 3'd2;
   localparam logic [2:0] STEP_UP     = 3'd3;
   localparam logic [2:0] STEP_DOWN   = 3'd4;
   localparam logic [2:0] STEP_WRITE  = 3'd5;

   localparam int CHANNELS = 3;
   localparam int PIX_BITS = 57;

   typedef struct packed {
      logic first;
      logic accum;
   } stn_ctrl_type;

endpackage
`default_nettype wire

// ===== src/psbj_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psbj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/psbj_stencil.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psbj_stencil import psbj_pkg::*; #(
   parameter int SB = 20,
   parameter int FB = 8
) (
   input  wire logic                     clock,
   input  wire stn_ctrl_type             ctrl,
   input  wire logic [CHANNELS*SB-1:0]   sol_in,
   input  wire logic [CHANNELS*8-1:0]    src_in,
   input  wire logic                     mask_in,
   output logic [CHANNELS*SB-1:0]        new_val,
   output logic [CHANNELS*SB-1:0]        cen_val,
   output logic                          cen_mask
);

   localparam int AB = SB + FB + 4;
   localparam logic signed [AB-1:0] SAT_HI = $signed((AB'(1) << (SB - 1)) - AB'(1));
   localparam logic signed [AB-1:0] SAT_LO = -SAT_HI - AB'(1);

   logic [CHANNELS*SB-1:0] cen_val_ff;
   logic                   cen_mask_ff;

   always_ff @(posedge clock) begin
      if (ctrl.first) begin
         cen_val_ff  <= sol_in;
         cen_mask_ff <= mask_in;
      end
   end

   assign cen_val  = cen_val_ff;
   assign cen_mask = cen_mask_ff;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic signed [SB-1:0] sol_c;
      logic signed [AB-1:0] acc_ff;
      logic signed [AB-1:0] acc_in;
      logic signed [AB-1:0] term;
      logic signed [AB-1:0] total;
      logic signed [AB-1:0] quarter;
      logic [AB-1:0]        src_ext;

      assign sol_c   = sol_in[c*SB +: SB];
      assign src_ext = AB'(src_in[c*8 +: 8]);
      assign term    = AB'(sol_c) - $signed(src_ext << FB);
      assign total   = acc_ff + term;
      assign quarter = (total + AB'(2)) >>> 2;

      always_comb begin
         if (ctrl.first) begin
            acc_in = $signed(src_ext << (FB + 2));
         end else if (ctrl.accum) begin
            acc_in = total;
         end else begin
            acc_in = acc_ff;
         end
         if (quarter > SAT_HI) begin
            new_val[c*SB +: SB] = SAT_HI[SB-1:0];
         end else if (quarter < SAT_LO) begin
            new_val[c*SB +: SB] = SAT_LO[SB-1:0];
         end else begin
            new_val[c*SB +: SB] = quarter[SB-1:0];
         end
      end

      always_ff @(posedge clock) begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/poisson_seamless_blend_jacobi.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Poisson blending by Jacobi sweeps. Load items write one pixel each; the block is always ready
// for them while loading. After the last load of a width by height image the block accepts no
// item until its sweeps are done: every pixel of every sweep reads its centre and, if interior,
// its four neighbours one after another through the single read port of the solution bank, then
// writes the new value into the other bank. Fetch items pass the memory read and then the output
// register, return pixels in raster order, and none is taken until the last response has left.
module poisson_seamless_blend_jacobi import psbj_pkg::*; #(
   parameter int MAX_WIDTH     = 128,
   parameter int MAX_HEIGHT    = 128,
   parameter int SOLUTION_BITS = 20,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [23:0] req_src_rgb,
   input  wire logic [31:0] req_dst_rgba,
   input  wire logic [7:0]  req_mask_alpha,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_out_rgba,
   output logic             rsp_last_pixel,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   localparam int SB    = SOLUTION_BITS;
   localparam int FB    = FRACTION_BITS;
   localparam int TOTAL = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(TOTAL);
   localparam int NB    = $clog2(TOTAL + 1);
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int HB    = $clog2(MAX_HEIGHT + 1);
   localparam int SW    = CHANNELS * SB;
   localparam logic [31:0] SOL_MAX = (32'd1 << (SB - 1)) - 32'd1;

   logic [7:0]  width_ff, width_in, height_ff, height_in, thresh_ff, thresh_in;
   logic [9:0]  sweeps_ff, sweeps_in;
   state_type   state_ff, state_in;
   logic [AW-1:0] load_pos_ff, load_pos_in, fetch_pos_ff, fetch_pos_in, idx_ff, idx_in;
   logic [WB-1:0] x_ff, x_in;
   logic [HB-1:0] y_ff, y_in;
   logic [2:0]  step_ff, step_in;
   logic [9:0]  sweep_cnt_ff, sweep_cnt_in;
   logic        cur_ff, cur_in;
   logic        pend_ff, pend_in, pend_last_ff, pend_last_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_rgba_ff, rsp_rgba_in;

   logic [WB-1:0] w_eff;
   logic [HB-1:0] h_eff;
   logic [NB-1:0] n_pix;
   logic          interior, accept;
   logic [AW-1:0] rd_addr;
   logic          pix_we, bank0_we, bank1_we;
   logic [PIX_BITS-1:0] pix_wdata, pix_rdata;
   logic [SW-1:0] init_val, bank0_wdata, bank1_wdata, sol0_rdata, sol1_rdata, sol_rdata;
   logic [SW-1:0] new_val, cen_val, sweep_wdata;
   logic          cen_mask;
   logic [31:0]   blended;
   stn_ctrl_type  stn_ctrl;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WB'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HB'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HB'(MAX_HEIGHT);
      end else begin
         h_eff = HB'(height_ff);
      end
   end

   assign n_pix    = NB'(32'(w_eff) * 32'(h_eff));
   assign interior = (x_ff != '0) && ((x_ff + WB'(1)) < w_eff)
                  && (y_ff != '0) && ((y_ff + HB'(1)) < h_eff);
   assign accept   = req_valid && req_ready;

   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD:  req_ready = 1'b1;
         ST_FETCH: req_ready = !pend_ff && !rsp_valid_ff;
         default:  req_ready = 1'b0;
      endcase
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_init
      logic [31:0] scaled;
      assign scaled = 32'(req_dst_rgba[c*8 +: 8]) << FB;
      assign init_val[c*SB +: SB] = (scaled > SOL_MAX) ? SOL_MAX[SB-1:0] : scaled[SB-1:0];
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_out
      logic [SB-1:0] v;
      logic [31:0]   r;
      assign v = sol_rdata[c*SB +: SB];
      assign r = (32'(v) + (32'd1 << (FB - 1))) >> FB;
      assign blended[c*8 +: 8] = v[SB-1] ? 8'h00 : ((r > 32'd255) ? 8'hFF : r[7:0]);
   end
   assign blended[31:24] = pix_rdata[55:48];

   always_comb begin
      rd_addr = idx_ff;
      if (state_ff == ST_FETCH) begin
         rd_addr = fetch_pos_ff;
      end else begin
         case (step_ff)
            STEP_LEFT:  rd_addr = interior ? idx_ff - AW'(1) : idx_ff;
            STEP_RIGHT: rd_addr = interior ? idx_ff + AW'(1) : idx_ff;
            STEP_UP:    rd_addr = interior ? idx_ff - AW'(w_eff) : idx_ff;
            STEP_DOWN:  rd_addr = interior ? idx_ff + AW'(w_eff) : idx_ff;
            default:    rd_addr = idx_ff;
         endcase
      end
   end

   assign sol_rdata      = cur_ff ? sol1_rdata : sol0_rdata;
   assign stn_ctrl.first = (state_ff == ST_SWEEP) && (step_ff == STEP_LEFT);
   assign stn_ctrl.accum = (state_ff == ST_SWEEP)
                        && ((step_ff == STEP_RIGHT) || (step_ff == STEP_UP)
                        || (step_ff == STEP_DOWN));
   assign sweep_wdata    = (interior && cen_mask) ? new_val : cen_val;

   assign pix_we    = accept && (state_ff == ST_LOAD) && (req_command == CMD_LOAD);
   assign pix_wdata = {(req_mask_alpha > thresh_ff), req_dst_rgba, req_src_rgb};
   assign bank0_we  = pix_we || ((state_ff == ST_SWEEP) && (step_ff == STEP_WRITE) && cur_ff);
   assign bank1_we  = (state_ff == ST_SWEEP) && (step_ff == STEP_WRITE) && !cur_ff;
   assign bank0_wdata = pix_we ? init_val : sweep_wdata;
   assign bank1_wdata = sweep_wdata;

   psbj_ram #(.WIDTH(PIX_BITS), .DEPTH(TOTAL)) u_pix_ram (
      .clock(clock), .wr_en(pix_we), .wr_addr(load_pos_ff), .wr_data(pix_wdata),
      .rd_addr(rd_addr), .rd_data(pix_rdata)
   );

   psbj_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_bank0_ram (
      .clock(clock), .wr_en(bank0_we), .wr_addr(pix_we ? load_pos_ff : idx_ff),
      .wr_data(bank0_wdata), .rd_addr(rd_addr), .rd_data(sol0_rdata)
   );

   psbj_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_bank1_ram (
      .clock(clock), .wr_en(bank1_we), .wr_addr(idx_ff), .wr_data(bank1_wdata),
      .rd_addr(rd_addr), .rd_data(sol1_rdata)
   );

   psbj_stencil #(.SB(SB), .FB(FB)) u_stencil (
      .clock(clock), .ctrl(stn_ctrl), .sol_in(sol_rdata), .src_in(pix_rdata[23:0]),
      .mask_in(pix_rdata[56]), .new_val(new_val), .cen_val(cen_val), .cen_mask(cen_mask)
   );

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      sweeps_in    = sweeps_ff;
      thresh_in    = thresh_ff;
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      fetch_pos_in = fetch_pos_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      step_in      = step_ff;
      sweep_cnt_in = sweep_cnt_ff;
      cur_in       = cur_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_last_in  = rsp_last_ff;
      rsp_rgba_in  = rsp_rgba_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:     width_in  = csr_data[7:0];
            CSR_HEIGHT:    height_in = csr_data[7:0];
            CSR_SWEEPS:    sweeps_in = csr_data;
            CSR_THRESHOLD: thresh_in = csr_data[7:0];
            default:       width_in  = width_ff;
         endcase
      end

      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = pend_last_ff;
         rsp_rgba_in  = pix_rdata[56] ? blended : pix_rdata[55:24];
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept && (req_command == CMD_LOAD)) begin
               if ((NB'(load_pos_ff) + NB'(1)) >= n_pix) begin
                  load_pos_in  = '0;
                  fetch_pos_in = '0;
                  idx_in       = '0;
                  x_in         = '0;
                  y_in         = '0;
                  step_in      = STEP_CENTRE;
                  sweep_cnt_in = '0;
                  cur_in       = 1'b0;
                  state_in     = (sweeps_ff == '0) ? ST_FETCH : ST_SWEEP;
               end else begin
                  load_pos_in = load_pos_ff + AW'(1);
               end
            end
         end
         ST_SWEEP: begin
            if (step_ff == STEP_WRITE) begin
               step_in = STEP_CENTRE;
               if ((NB'(idx_ff) + NB'(1)) >= n_pix) begin
                  idx_in       = '0;
                  x_in         = '0;
                  y_in         = '0;
                  cur_in       = !cur_ff;
                  sweep_cnt_in = sweep_cnt_ff + 10'd1;
                  if ((sweep_cnt_ff + 10'd1) >= sweeps_ff) begin
                     state_in = ST_FETCH;
                  end
               end else begin
                  idx_in = idx_ff + AW'(1);
                  if ((x_ff + WB'(1)) >= w_eff) begin
                     x_in = '0;
                     y_in = y_ff + HB'(1);
                  end else begin
                     x_in = x_ff + WB'(1);
                  end
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_FETCH: begin
            if (accept && (req_command == CMD_FETCH)) begin
               pend_in = 1'b1;
               if ((NB'(fetch_pos_ff) + NB'(1)) >= n_pix) begin
                  pend_last_in = 1'b1;
                  fetch_pos_in = '0;
                  state_in     = ST_LOAD;
               end else begin
                  pend_last_in = 1'b0;
                  fetch_pos_in = fetch_pos_ff + AW'(1);
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 8'd128;
         height_ff    <= 8'd128;
         sweeps_ff    <= 10'd180;
         thresh_ff    <= 8'd20;
         state_ff     <= ST_LOAD;
         load_pos_ff  <= '0;
         fetch_pos_ff <= '0;
         idx_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         step_ff      <= STEP_CENTRE;
         sweep_cnt_ff <= '0;
         cur_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         sweeps_ff    <= sweeps_in;
         thresh_ff    <= thresh_in;
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         fetch_pos_ff <= fetch_pos_in;
         idx_ff       <= idx_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         step_ff      <= step_in;
         sweep_cnt_ff <= sweep_cnt_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_last_ff <= pend_last_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_rgba_ff  <= rsp_rgba_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_rgba   = rsp_rgba_ff;
   assign rsp_last_pixel = rsp_last_ff;

   a_pend_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && rsp_valid_ff))
      else $error("Read pending while an item is waiting at the output.");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_WRITE)
      else $error("Stencil step out of range.");

   a_bank_read_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ((cur_ff && !bank1_we) || (!cur_ff && !bank0_we)))
      else $error("A sweep wrote the bank it reads.");

endmodule
`default_nettype wire
